### hdl/adpcmv_pkg.sv
// shared types, constants and tables for the variable width adpcm encoder
`default_nettype none
package adpcmv_pkg;

    localparam int SAMPLE_W         = 16;
    localparam int IDX_W            = 7;
    localparam int CODE_W           = 5;
    localparam int STEP_W           = 15;
    localparam int FRAME_W          = 12;
    localparam int SPB_W            = 13;
    localparam int BPC_W            = 3;
    localparam int CHC_W            = 2;
    localparam int ADJ_W            = 5;
    localparam int QUEUE_DEPTH      = 2;
    localparam int DEF_MAX_CHANNELS = 2;
    localparam int APB_ADDR_W       = 4;
    localparam int APB_DATA_W       = 32;

    localparam logic [IDX_W-1:0]    IDX_MAX  = 7'd88;
    localparam logic [BPC_W-1:0]    BPC_MIN  = 3'd2;
    localparam logic [BPC_W-1:0]    BPC_MAX  = 3'd5;
    localparam logic [BPC_W-1:0]    BPC_DEF  = 3'd4;
    localparam logic [CHC_W-1:0]    CHC_DEF  = 2'd2;
    localparam logic [SPB_W-1:0]    SPB_DEF  = 13'd505;
    localparam logic [SPB_W-1:0]    SPB_MIN  = 13'd2;
    localparam logic [SPB_W-1:0]    SPB_MAX  = 13'd4096;

    localparam logic [BPC_W-1:0]    BPC_2    = 3'd2;
    localparam logic [BPC_W-1:0]    BPC_3    = 3'd3;
    localparam logic [BPC_W-1:0]    BPC_4    = 3'd4;
    localparam logic [BPC_W-1:0]    BPC_5    = 3'd5;

    typedef enum logic [1:0] {
        REG_BPC = 2'd0,
        REG_CHC = 2'd1,
        REG_SPB = 2'd2
    } t_reg_idx;

    typedef struct packed {
        logic                       hdr;
        logic                       ch;
        logic signed [SAMPLE_W-1:0] sample;
    } t_item;

    localparam logic [STEP_W-1:0] STEP_TAB [0:88] = '{
        15'd7, 15'd8, 15'd9, 15'd10, 15'd11, 15'd12, 15'd13, 15'd14,
        15'd16, 15'd17, 15'd19, 15'd21, 15'd23, 15'd25, 15'd28, 15'd31,
        15'd34, 15'd37, 15'd41, 15'd45, 15'd50, 15'd55, 15'd60, 15'd66,
        15'd73, 15'd80, 15'd88, 15'd97, 15'd107, 15'd118, 15'd130, 15'd143,
        15'd157, 15'd173, 15'd190, 15'd209, 15'd230, 15'd253, 15'd279, 15'd307,
        15'd337, 15'd371, 15'd408, 15'd449, 15'd494, 15'd544, 15'd598, 15'd658,
        15'd724, 15'd796, 15'd876, 15'd963, 15'd1060, 15'd1166, 15'd1282, 15'd1411,
        15'd1552, 15'd1707, 15'd1878, 15'd2066, 15'd2272, 15'd2499, 15'd2749,
        15'd3024, 15'd3327, 15'd3660, 15'd4026, 15'd4428, 15'd4871, 15'd5358,
        15'd5894, 15'd6484, 15'd7132, 15'd7845, 15'd8630, 15'd9493, 15'd10442,
        15'd11487, 15'd12635, 15'd13899, 15'd15289, 15'd16818, 15'd18500,
        15'd20350, 15'd22385, 15'd24623, 15'd27086, 15'd29794, 15'd32767
    };

    localparam logic [ADJ_W-1:0] ADJ5 [0:7] = '{
        5'd1, 5'd2, 5'd4, 5'd6, 5'd8, 5'd10, 5'd13, 5'd16
    };
    localparam logic [ADJ_W-1:0] ADJ4 [0:3] = '{5'd2, 5'd4, 5'd6, 5'd8};
    localparam logic [ADJ_W-1:0] ADJ3 [0:1] = '{5'd1, 5'd2};
    localparam logic [ADJ_W-1:0] ADJ2       = 5'd2;

endpackage
`default_nettype wire

### hdl/adpcm_encoder_variable_bits_top.sv
// top level of the variable width adpcm encoder with its register port
//
// Encodes one signed 16-bit sample per accepted request, channels taken in
// turn, and returns one result per sample: a header flag, the channel, the
// updated predictor, the step index and a code of 2 to 5 bits. A new sample
// can be accepted every cycle while the request queue is not full (o_stall
// low); an accepted sample is written into the request queue, then passes the
// combinational quantizer and predictor update into the result register of the
// back end, which holds the state of both channels.
// Registers at byte addresses 0, 4 and 8: bits per code, channel count and
// samples per block; write them only while no sample is in flight.
`default_nettype none
module adpcm_encoder_variable_bits_top
    import adpcmv_pkg::*;
#(
    parameter int MAX_CHANNELS = DEF_MAX_CHANNELS
) (
    input  wire logic                       i_clk,
    input  wire logic                       i_rst_n,
    input  wire logic                       psel,
    input  wire logic                       penable,
    input  wire logic                       pwrite,
    input  wire logic [APB_ADDR_W-1:0]      paddr,
    input  wire logic [APB_DATA_W-1:0]      pwdata,
    output logic [APB_DATA_W-1:0]           prdata,
    output logic                            pready,
    input  wire logic                       i_valid,
    output logic                            o_stall,
    input  wire logic signed [SAMPLE_W-1:0] i_pcm_sample,
    output logic                            o_valid,
    input  wire logic                       i_stall,
    output logic                            o_is_header,
    output logic                            o_channel,
    output logic signed [SAMPLE_W-1:0]      o_predicted_sample,
    output logic [IDX_W-1:0]                o_step_index,
    output logic [CODE_W-1:0]               o_code
);

    logic [BPC_W-1:0] r_bpc;
    logic [CHC_W-1:0] r_chc;
    logic [SPB_W-1:0] r_spb;
    logic             wr_en;
    t_reg_idx         reg_sel;

    logic             q_push;
    logic             q_full;
    logic             q_pop;
    logic             q_empty;
    t_item            front_item;
    t_item            head_item;

    assign pready  = 1'b1;
    assign wr_en   = psel && penable && pwrite && pready;
    assign reg_sel = t_reg_idx'(paddr[3:2]);

    always_comb begin
        case (reg_sel)
            REG_BPC: prdata = {{(APB_DATA_W-BPC_W){1'b0}}, r_bpc};
            REG_CHC: prdata = {{(APB_DATA_W-CHC_W){1'b0}}, r_chc};
            REG_SPB: prdata = {{(APB_DATA_W-SPB_W){1'b0}}, r_spb};
            default: prdata = '0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_bpc <= BPC_DEF;
            r_chc <= CHC_DEF;
            r_spb <= SPB_DEF;
        end else if (wr_en) begin
            case (reg_sel)
                REG_BPC: r_bpc <= pwdata[BPC_W-1:0];
                REG_CHC: r_chc <= pwdata[CHC_W-1:0];
                REG_SPB: r_spb <= pwdata[SPB_W-1:0];
                default: ;
            endcase
        end
    end

    adpcmv_front #(
        .MAX_CHANNELS (MAX_CHANNELS)
    ) u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_chc    (r_chc),
        .i_cfg_spb    (r_spb),
        .i_valid      (i_valid),
        .o_stall      (o_stall),
        .i_pcm_sample (i_pcm_sample),
        .i_full       (q_full),
        .o_push       (q_push),
        .o_item       (front_item)
    );

    adpcmv_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_item  (front_item),
        .o_full  (q_full),
        .i_pop   (q_pop),
        .o_item  (head_item),
        .o_empty (q_empty)
    );

    adpcmv_back #(
        .MAX_CHANNELS (MAX_CHANNELS)
    ) u_back (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_cfg_bpc          (r_bpc),
        .i_item             (head_item),
        .i_empty            (q_empty),
        .o_pop              (q_pop),
        .o_valid            (o_valid),
        .i_stall            (i_stall),
        .o_is_header        (o_is_header),
        .o_channel          (o_channel),
        .o_predicted_sample (o_predicted_sample),
        .o_step_index       (o_step_index),
        .o_code             (o_code)
    );

endmodule
`default_nettype wire

### hdl/adpcmv_front.sv
// front end: tracks channel and frame position and tags each request
`default_nettype none
module adpcmv_front
    import adpcmv_pkg::*;
#(
    parameter int MAX_CHANNELS = DEF_MAX_CHANNELS
) (
    input  wire logic                       i_clk,
    input  wire logic                       i_rst_n,
    input  wire logic [CHC_W-1:0]           i_cfg_chc,
    input  wire logic [SPB_W-1:0]           i_cfg_spb,
    input  wire logic                       i_valid,
    output logic                            o_stall,
    input  wire logic signed [SAMPLE_W-1:0] i_pcm_sample,
    input  wire logic                       i_full,
    output logic                            o_push,
    output t_item                           o_item
);

    logic [FRAME_W-1:0] r_frame;
    logic [FRAME_W-1:0] n_frame;
    logic               r_chan;
    logic               n_chan;
    logic [CHC_W-1:0]   chans;
    logic [SPB_W-1:0]   spb;
    logic [FRAME_W-1:0] frame_inc;
    logic               last_chan;

    assign o_stall = i_full;
    assign o_push  = i_valid && !i_full;

    always_comb begin
        o_item.hdr    = (r_frame == '0);
        o_item.ch     = r_chan;
        o_item.sample = i_pcm_sample;
    end

    always_comb begin
        chans = (i_cfg_chc == 2'd1) ? 2'd1 : 2'd2;
        if (chans > CHC_W'(MAX_CHANNELS)) begin
            chans = CHC_W'(MAX_CHANNELS);
        end
        spb = i_cfg_spb;
        if (spb < SPB_MIN) begin
            spb = SPB_MIN;
        end
        if (spb > SPB_MAX) begin
            spb = SPB_MAX;
        end
        last_chan = (({1'b0, r_chan} + 2'd1) >= chans);
        frame_inc = r_frame + 1'b1;
        n_frame   = r_frame;
        n_chan    = r_chan;
        if (o_push) begin
            if (last_chan) begin
                n_chan = 1'b0;
                if ({1'b0, frame_inc} >= spb) begin
                    n_frame = '0;
                end else begin
                    n_frame = frame_inc;
                end
            end else begin
                n_chan = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_frame <= '0;
            r_chan  <= 1'b0;
        end else begin
            r_frame <= n_frame;
            r_chan  <= n_chan;
        end
    end

endmodule
`default_nettype wire

### hdl/adpcmv_queue.sv
// short request queue between the front and back ends
`default_nettype none
module adpcmv_queue
    import adpcmv_pkg::*;
(
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    input  wire logic  i_push,
    input  wire t_item i_item,
    output logic       o_full,
    input  wire logic  i_pop,
    output t_item      o_item,
    output logic       o_empty
);

    localparam int QAW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int QCW = $clog2(QUEUE_DEPTH + 1);

    t_item            r_mem [QUEUE_DEPTH];
    logic [QAW-1:0]   r_wr;
    logic [QAW-1:0]   n_wr;
    logic [QAW-1:0]   r_rd;
    logic [QAW-1:0]   n_rd;
    logic [QCW-1:0]   r_count;
    logic [QCW-1:0]   n_count;
    logic             do_push;
    logic             do_pop;

    assign o_full  = (r_count == QCW'(QUEUE_DEPTH));
    assign o_empty = (r_count == '0);
    assign o_item  = r_mem[r_rd];
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && !o_empty;

    always_comb begin
        n_wr    = r_wr;
        n_rd    = r_rd;
        n_count = r_count;
        if (do_push) begin
            n_wr = (r_wr == QAW'(QUEUE_DEPTH - 1)) ? '0 : r_wr + 1'b1;
        end
        if (do_pop) begin
            n_rd = (r_rd == QAW'(QUEUE_DEPTH - 1)) ? '0 : r_rd + 1'b1;
        end
        if (do_push && !do_pop) begin
            n_count = r_count + 1'b1;
        end else if (do_pop && !do_push) begin
            n_count = r_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr] <= i_item;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_count <= '0;
        end else begin
            r_wr    <= n_wr;
            r_rd    <= n_rd;
            r_count <= n_count;
        end
    end

endmodule
`default_nettype wire

### hdl/adpcmv_back.sv
// back end: per-channel predictor state, quantizer and result register
`default_nettype none
module adpcmv_back
    import adpcmv_pkg::*;
#(
    parameter int MAX_CHANNELS = DEF_MAX_CHANNELS
) (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic [BPC_W-1:0]     i_cfg_bpc,
    input  wire t_item                i_item,
    input  wire logic                 i_empty,
    output logic                      o_pop,
    output logic                      o_valid,
    input  wire logic                 i_stall,
    output logic                      o_is_header,
    output logic                      o_channel,
    output logic signed [SAMPLE_W-1:0] o_predicted_sample,
    output logic [IDX_W-1:0]          o_step_index,
    output logic [CODE_W-1:0]         o_code
);

    logic signed [SAMPLE_W-1:0] r_pred [MAX_CHANNELS];
    logic [IDX_W-1:0]           r_pos  [MAX_CHANNELS];
    logic                       r_valid;
    logic                       r_hdr;
    logic                       r_ch;
    logic signed [SAMPLE_W-1:0] r_out_pred;
    logic [IDX_W-1:0]           r_out_idx;
    logic [CODE_W-1:0]          r_code;

    logic signed [SAMPLE_W-1:0] n_pred;
    logic [IDX_W-1:0]           n_idx;
    logic [CODE_W-1:0]          n_code;

    logic [BPC_W-1:0]           bpc;
    logic [BPC_W-1:0]           nmag;
    logic signed [SAMPLE_W-1:0] pred;
    logic [IDX_W-1:0]           pos;
    logic [IDX_W-1:0]           idx;
    logic [STEP_W-1:0]          step;
    logic [STEP_W-1:0]          step_b;
    logic signed [SAMPLE_W:0]   diff_s;
    logic [SAMPLE_W:0]          diff_n;
    logic                       neg;
    logic [SAMPLE_W-1:0]        rem;
    logic [SAMPLE_W:0]          recon;
    logic [3:0]                 mag;
    logic                       qbit;
    logic                       upper;
    logic [ADJ_W-1:0]           adj;
    logic signed [IDX_W:0]      nidx;
    logic signed [SAMPLE_W+2:0] psum;

    assign o_pop              = !i_empty && (!r_valid || !i_stall);
    assign o_valid            = r_valid;
    assign o_is_header        = r_hdr;
    assign o_channel          = r_ch;
    assign o_predicted_sample = r_out_pred;
    assign o_step_index       = r_out_idx;
    assign o_code             = r_code;

    always_comb begin
        bpc = (i_cfg_bpc >= BPC_MIN && i_cfg_bpc <= BPC_MAX) ? i_cfg_bpc : BPC_DEF;
        nmag   = bpc - 1'b1;
        pred   = r_pred[i_item.ch];
        pos    = r_pos[i_item.ch];
        idx    = (pos > IDX_MAX) ? IDX_MAX : pos;
        step   = STEP_TAB[idx];
        diff_s = {i_item.sample[SAMPLE_W-1], i_item.sample} - {pred[SAMPLE_W-1], pred};
        neg    = diff_s[SAMPLE_W];
        diff_n = ~diff_s + 1'b1;
        rem    = neg ? diff_n[SAMPLE_W-1:0] : diff_s[SAMPLE_W-1:0];
        mag    = '0;
        step_b = '0;
        qbit   = 1'b0;

        // magnitude: one compare and subtract per magnitude bit
        if (bpc == BPC_2) begin
            recon = {3'b000, step[STEP_W-1:1]};
            if (rem >= {2'b00, step[STEP_W-1:1]}) begin
                mag   = 4'd1;
                recon = recon + {2'b00, step};
            end
        end else begin
            recon = {2'b00, step >> nmag};
            for (int b = 0; b < 4; b++) begin
                if (b < int'(nmag)) begin
                    step_b = step >> b;
                    qbit   = (rem >= {1'b0, step_b});
                    mag    = {mag[2:0], qbit};
                    if (qbit) begin
                        rem   = rem - {1'b0, step_b};
                        recon = recon + {2'b00, step_b};
                    end
                end
            end
        end

        case (bpc)
            BPC_5: begin
                upper  = mag[3];
                adj    = ADJ5[mag[2:0]];
                n_code = {neg, mag[3:0]};
            end
            BPC_4: begin
                upper  = mag[2];
                adj    = ADJ4[mag[1:0]];
                n_code = {1'b0, neg, mag[2:0]};
            end
            BPC_3: begin
                upper  = mag[1];
                adj    = ADJ3[mag[0]];
                n_code = {2'b00, neg, mag[1:0]};
            end
            default: begin
                upper  = mag[0];
                adj    = ADJ2;
                n_code = {3'b000, neg, mag[0]};
            end
        endcase

        nidx = upper ? $signed({1'b0, idx}) + $signed({3'b000, adj})
                     : $signed({1'b0, idx}) - 8'sd1;
        if (nidx[IDX_W]) begin
            n_idx = '0;
        end else if (nidx[IDX_W-1:0] > IDX_MAX) begin
            n_idx = IDX_MAX;
        end else begin
            n_idx = nidx[IDX_W-1:0];
        end

        psum = neg ? $signed({{3{pred[SAMPLE_W-1]}}, pred}) - $signed({2'b00, recon})
                   : $signed({{3{pred[SAMPLE_W-1]}}, pred}) + $signed({2'b00, recon});
        if (psum > 19'sd32767) begin
            n_pred = 16'sd32767;
        end else if (psum < -19'sd32768) begin
            n_pred = -16'sd32768;
        end else begin
            n_pred = psum[SAMPLE_W-1:0];
        end

        // header sample loads the predictor and keeps the index
        if (i_item.hdr) begin
            n_pred = i_item.sample;
            n_idx  = pos;
            n_code = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int c = 0; c < MAX_CHANNELS; c++) begin
                r_pred[c] <= '0;
                r_pos[c]  <= '0;
            end
        end else if (o_pop) begin
            r_pred[i_item.ch] <= n_pred;
            r_pos[i_item.ch]  <= n_idx;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_pop) begin
            r_valid <= 1'b1;
        end else if (!i_stall) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_hdr      <= i_item.hdr;
            r_ch       <= i_item.ch;
            r_out_pred <= n_pred;
            r_out_idx  <= n_idx;
            r_code     <= n_code;
        end
    end

endmodule
`default_nettype wire
